[hw/rtl/query_parameter_locator_defines.svh]
// Assertion macros shared by the query parameter locator RTL.
// No dependencies; included by modules that carry assertions.
`ifndef QUERY_PARAMETER_LOCATOR_DEFINES_SVH
`define QUERY_PARAMETER_LOCATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define QPL_ASSERT_IMPL(label, ck, rn, ante, cons) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("qpl: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define QPL_ASSERT_NEXT(label, ck, rn, ante, cons) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("qpl: assertion failed");

`endif

[hw/rtl/qpl_pkg.sv]
// Package for the query parameter locator: widths, characters, register
// indexes, scan phases and the structs passed between modules. No dependencies.
`timescale 1ns / 1ps

package qpl_pkg;

  localparam int OFS_W             = 13;
  localparam int KEY_LEN_W         = 6;
  localparam int KEY_BYTES         = 32;
  localparam int CFG_DATA_W        = 64;
  localparam int CFG_IDX_W         = 3;
  localparam int DEF_MAX_QUERY_LEN = 4096;
  localparam int DEF_MAX_KEY_LEN   = 32;

  localparam logic [7:0] CHAR_AMP = 8'h26;  // '&'
  localparam logic [7:0] CHAR_EQ  = 8'h3D;  // '='

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY_LENGTH    = 3'd0,
    REG_KEY_LOW       = 3'd1,
    REG_KEY_MID_LOW   = 3'd2,
    REG_KEY_MID_HIGH  = 3'd3,
    REG_KEY_HIGH      = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    PH_SEARCH  = 2'd0,
    PH_EQ_SEEN = 2'd1,
    PH_VALUE   = 2'd2,
    PH_DONE    = 2'd3
  } phase_t;

  typedef struct packed {
    logic [KEY_LEN_W-1:0]   key_len;
    logic [8*KEY_BYTES-1:0] key_bytes;
  } cfg_t;

  typedef struct packed {
    logic             found;
    logic [OFS_W-1:0] key_offset;
    logic [OFS_W-1:0] value_offset;
    logic [OFS_W-1:0] value_end_offset;
    logic             too_long;
  } res_t;

endpackage

[hw/rtl/qpl_if.sv]
// Valid/ready channel interfaces for query bytes and scan results.
// No dependencies.
`timescale 1ns / 1ps

interface qpl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] query_byte;
  logic       end_of_string;

  modport source (output valid, query_byte, end_of_string, input ready);
  modport sink   (input valid, query_byte, end_of_string, output ready);
endinterface

interface qpl_out_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [12:0] key_offset;
  logic [12:0] value_offset;
  logic [12:0] value_end_offset;
  logic        too_long;

  modport source (output valid, found, key_offset, value_offset, value_end_offset,
                  too_long, input ready);
  modport sink   (input valid, found, key_offset, value_offset, value_end_offset,
                  too_long, output ready);
endinterface

[hw/rtl/qpl_cfg_regs.sv]
// Configuration registers: key length and the 32 key bytes.
// Depends on qpl_pkg.
`timescale 1ns / 1ps

module qpl_cfg_regs (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [qpl_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [qpl_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  output qpl_pkg::cfg_t                       cfg
);

  qpl_pkg::cfg_t cfg_r;
  qpl_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        qpl_pkg::REG_KEY_LENGTH:   cfg_nxt.key_len = cfg_wdata[qpl_pkg::KEY_LEN_W-1:0];
        qpl_pkg::REG_KEY_LOW:      cfg_nxt.key_bytes[0   +: 64] = cfg_wdata;
        qpl_pkg::REG_KEY_MID_LOW:  cfg_nxt.key_bytes[64  +: 64] = cfg_wdata;
        qpl_pkg::REG_KEY_MID_HIGH: cfg_nxt.key_bytes[128 +: 64] = cfg_wdata;
        qpl_pkg::REG_KEY_HIGH:     cfg_nxt.key_bytes[192 +: 64] = cfg_wdata;
        default: ;  // unmapped index, dropped
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

[hw/rtl/qpl_key_match.sv]
// Shift-and key matcher: advances every open field-start attempt by one byte.
// Depends on qpl_pkg.
`timescale 1ns / 1ps

module qpl_key_match #(
  parameter int MAX_KEY_LEN = qpl_pkg::DEF_MAX_KEY_LEN
) (
  input  qpl_pkg::cfg_t           cfg,
  input  logic [7:0]              qbyte,
  input  logic [MAX_KEY_LEN-1:0]  mask_in,
  input  logic                    fs_in,
  output logic [MAX_KEY_LEN-1:0]  mask_out,
  output logic                    hit,
  output logic                    len_ok
);

  logic [MAX_KEY_LEN-1:0] eq;
  logic [MAX_KEY_LEN-1:0] last_sel;

  always_comb begin
    for (int j = 0; j < MAX_KEY_LEN; j++) begin
      eq[j]       = (cfg.key_bytes[8*j +: 8] == qbyte) &&
                    (qpl_pkg::KEY_LEN_W'(j) < cfg.key_len);
      last_sel[j] = (cfg.key_len == qpl_pkg::KEY_LEN_W'(j + 1));
    end
  end

  // bit j set: key bytes 0..j matched, ending at this byte
  assign mask_out = ((mask_in << 1) | MAX_KEY_LEN'(fs_in)) & eq;
  assign hit      = |(mask_out & last_sel);
  assign len_ok   = (cfg.key_len != '0) &&
                    (cfg.key_len <= qpl_pkg::KEY_LEN_W'(MAX_KEY_LEN));

endmodule

[hw/rtl/qpl_scan_core.sv]
// Per-string scan state and result register; one byte retired per cycle unless a final byte waits for room.
// Depends on qpl_pkg, qpl_key_match and the assertion macro header.
`timescale 1ns / 1ps
`include "query_parameter_locator_defines.svh"

module qpl_scan_core #(
  parameter int MAX_QUERY_LEN = qpl_pkg::DEF_MAX_QUERY_LEN,
  parameter int MAX_KEY_LEN   = qpl_pkg::DEF_MAX_KEY_LEN
) (
  input  logic           clk,
  input  logic           rst_n,
  input  qpl_pkg::cfg_t  cfg,
  input  logic           item_vld,
  input  logic [7:0]     item_byte,
  input  logic           item_eos,
  output logic           item_take,
  input  logic           res_ready,
  output logic           res_vld,
  output qpl_pkg::res_t  res
);

  localparam int POS_W = $clog2(MAX_QUERY_LEN + 1);
  localparam int OFS_W = qpl_pkg::OFS_W;
  localparam int EXT_W = (POS_W > OFS_W) ? POS_W : OFS_W;

  logic [POS_W-1:0]       pos_r, pos_nxt;
  qpl_pkg::phase_t        phase_r, phase_nxt;
  logic [MAX_KEY_LEN-1:0] mask_r, mask_nxt;
  logic                   fs_r, fs_nxt;
  logic                   pend_r, pend_nxt;
  logic [OFS_W-1:0]       key_off_r, key_off_nxt;
  logic [OFS_W-1:0]       val_off_r, val_off_nxt;
  logic [OFS_W-1:0]       val_end_r, val_end_nxt;
  logic                   match_r, match_nxt;
  logic                   ovf_r, ovf_nxt;
  logic                   res_vld_r, res_vld_nxt;
  qpl_pkg::res_t          res_r, res_nxt;

  logic                   fire;
  logic [POS_W-1:0]       pos_inc;
  logic [EXT_W-1:0]       pos_ext, inc_ext, end_ext;
  logic [MAX_KEY_LEN-1:0] km_mask;
  logic                   km_hit, km_len_ok;
  logic                   is_amp;

  qpl_key_match #(.MAX_KEY_LEN(MAX_KEY_LEN)) u_match (
    .cfg      (cfg),
    .qbyte    (item_byte),
    .mask_in  (mask_r),
    .fs_in    (fs_r),
    .mask_out (km_mask),
    .hit      (km_hit),
    .len_ok   (km_len_ok)
  );

  // a final byte needs room in the result register; others always go
  assign item_take = !item_eos || !res_vld_r || res_ready;
  assign fire      = item_vld && item_take;
  assign is_amp    = (item_byte == qpl_pkg::CHAR_AMP);
  assign pos_inc   = pos_r + POS_W'(1);
  assign pos_ext   = EXT_W'(pos_r);
  assign inc_ext   = EXT_W'(pos_inc);

  always_comb begin
    pos_nxt     = pos_r;
    phase_nxt   = phase_r;
    mask_nxt    = mask_r;
    fs_nxt      = fs_r;
    pend_nxt    = pend_r;
    key_off_nxt = key_off_r;
    val_off_nxt = val_off_r;
    val_end_nxt = val_end_r;
    match_nxt   = match_r;
    ovf_nxt     = ovf_r;
    res_nxt     = res_r;
    res_vld_nxt = res_vld_r && !res_ready;

    if (fire && !ovf_r) begin
      if (pos_r >= POS_W'(MAX_QUERY_LEN)) begin
        ovf_nxt = 1'b1;
      end else begin
        pos_nxt = pos_inc;
        unique case (phase_r)
          qpl_pkg::PH_SEARCH: begin
            if (pend_r && item_byte == qpl_pkg::CHAR_EQ) begin
              phase_nxt   = qpl_pkg::PH_EQ_SEEN;
              key_off_nxt = pos_ext[OFS_W-1:0] - OFS_W'(cfg.key_len);
              val_off_nxt = inc_ext[OFS_W-1:0];
              pend_nxt    = 1'b0;
            end else if (!km_len_ok) begin
              mask_nxt = '0;
              pend_nxt = 1'b0;
              fs_nxt   = is_amp;
            end else begin
              mask_nxt = km_mask;
              pend_nxt = km_hit;
              fs_nxt   = is_amp;
            end
          end
          qpl_pkg::PH_EQ_SEEN: begin
            match_nxt = 1'b1;
            if (is_amp) begin
              val_end_nxt = pos_ext[OFS_W-1:0];
              phase_nxt   = qpl_pkg::PH_DONE;
            end else begin
              phase_nxt = qpl_pkg::PH_VALUE;
            end
          end
          qpl_pkg::PH_VALUE: begin
            if (is_amp) begin
              val_end_nxt = pos_ext[OFS_W-1:0];
              phase_nxt   = qpl_pkg::PH_DONE;
            end
          end
          qpl_pkg::PH_DONE: ;
          default: ;
        endcase
      end
    end

    // string length after this byte, taken before the restart below
    end_ext = EXT_W'(pos_nxt);

    if (fire && item_eos) begin
      res_vld_nxt = 1'b1;
      if (ovf_nxt || !match_nxt) begin
        res_nxt          = '0;
        res_nxt.too_long = ovf_nxt;
      end else begin
        res_nxt.found            = 1'b1;
        res_nxt.key_offset       = key_off_nxt;
        res_nxt.value_offset     = val_off_nxt;
        res_nxt.value_end_offset = (phase_nxt == qpl_pkg::PH_VALUE) ?
                                   end_ext[OFS_W-1:0] : val_end_nxt;
        res_nxt.too_long         = 1'b0;
      end
      // next byte starts a new string
      pos_nxt     = '0;
      phase_nxt   = qpl_pkg::PH_SEARCH;
      mask_nxt    = '0;
      fs_nxt      = 1'b1;
      pend_nxt    = 1'b0;
      key_off_nxt = '0;
      val_off_nxt = '0;
      val_end_nxt = '0;
      match_nxt   = 1'b0;
      ovf_nxt     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      phase_r   <= qpl_pkg::PH_SEARCH;
      mask_r    <= '0;
      fs_r      <= 1'b1;
      pend_r    <= 1'b0;
      key_off_r <= '0;
      val_off_r <= '0;
      val_end_r <= '0;
      match_r   <= 1'b0;
      ovf_r     <= 1'b0;
      res_vld_r <= 1'b0;
    end else begin
      pos_r     <= pos_nxt;
      phase_r   <= phase_nxt;
      mask_r    <= mask_nxt;
      fs_r      <= fs_nxt;
      pend_r    <= pend_nxt;
      key_off_r <= key_off_nxt;
      val_off_r <= val_off_nxt;
      val_end_r <= val_end_nxt;
      match_r   <= match_nxt;
      ovf_r     <= ovf_nxt;
      res_vld_r <= res_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign res_vld = res_vld_r;
  assign res     = res_r;

  `QPL_ASSERT_IMPL(a_pos_bound, clk, rst_n, 1'b1, pos_r <= POS_W'(MAX_QUERY_LEN))
  `QPL_ASSERT_NEXT(a_eos_clears, clk, rst_n, fire && item_eos,
                   pos_r == '0 && phase_r == qpl_pkg::PH_SEARCH && res_vld_r)
  `QPL_ASSERT_IMPL(a_no_pend_after_key, clk, rst_n, phase_r != qpl_pkg::PH_SEARCH, !pend_r)
  `QPL_ASSERT_IMPL(a_found_not_long, clk, rst_n, res_vld_r && res_r.found, !res_r.too_long)
endmodule

[hw/rtl/query_parameter_locator.sv]
// Query parameter locator: a final byte passes the input register, then the result
// register, which stalls it while it still holds a result that is not taken.
// Throughput 1 byte per cycle unless so stalled; the byte-position update and key match
// close in one stage. Synchronous active-low reset clears the key registers to zero
// and the scan state to the start of a new string; no clearing pass.
`timescale 1ns / 1ps

module query_parameter_locator #(
  parameter int MAX_QUERY_LEN = qpl_pkg::DEF_MAX_QUERY_LEN,
  parameter int MAX_KEY_LEN   = qpl_pkg::DEF_MAX_KEY_LEN
) (
  input  logic                             clk,
  input  logic                             rst_n,
  qpl_in_if.sink                           in_req,
  qpl_out_if.source                        out_res,
  input  logic                             cfg_wr_en,
  input  logic [qpl_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [qpl_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  qpl_pkg::cfg_t cfg;
  qpl_pkg::res_t res;
  logic          res_vld;
  logic          core_take;

  logic          in_vld_r, in_vld_nxt;
  logic [7:0]    in_byte_r;
  logic          in_eos_r;
  logic          in_accept;

  qpl_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // input register: refills in the same cycle the core takes its byte
  assign in_req.ready = !in_vld_r || core_take;
  assign in_accept    = in_req.valid && in_req.ready;
  assign in_vld_nxt   = in_accept || (in_vld_r && !core_take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_byte_r <= in_req.query_byte;
      in_eos_r  <= in_req.end_of_string;
    end
  end

  qpl_scan_core #(
    .MAX_QUERY_LEN (MAX_QUERY_LEN),
    .MAX_KEY_LEN   (MAX_KEY_LEN)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .item_vld  (in_vld_r),
    .item_byte (in_byte_r),
    .item_eos  (in_eos_r),
    .item_take (core_take),
    .res_ready (out_res.ready),
    .res_vld   (res_vld),
    .res       (res)
  );

  assign out_res.valid            = res_vld;
  assign out_res.found            = res.found;
  assign out_res.key_offset       = res.key_offset;
  assign out_res.value_offset     = res.value_offset;
  assign out_res.value_end_offset = res.value_end_offset;
  assign out_res.too_long         = res.too_long;

endmodule
